FILE: hw/rtl/ghrm_pkg.sv
// Shared types, constants and mapping functions of the gamepad report mapper.
package ghrm_pkg;

  localparam int MAX_REPORT_BYTES = 128;
  localparam int CAP_DEPTH        = 12;
  localparam int CAP_IDX_W        = $clog2(CAP_DEPTH);
  localparam int LEN_W            = $clog2(MAX_REPORT_BYTES + 1);
  localparam int PAYLOAD_BYTES    = 11;
  localparam int PREFIXED_MIN_LEN = 78;
  localparam int NEED_COMPAT      = 10;
  localparam int NEED_FULL        = 11;

  localparam logic [7:0] PREFIX_A    = 8'h31;
  localparam logic [7:0] PREFIX_B    = 8'h11;
  localparam logic [3:0] DPAD_NEUTRAL = 4'h8;

  localparam logic [1:0] MODE_FULL = 2'd1;

  localparam int DZ_W    = 15;
  localparam int DZ_SQ_W = 2 * DZ_W;
  localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [1:0] LAYOUT_MODE_RST   = 2'd1;

  localparam logic [1:0] REG_LAYOUT_MODE    = 2'd0;
  localparam logic [1:0] REG_LEFT_DEADZONE  = 2'd1;
  localparam logic [1:0] REG_RIGHT_DEADZONE = 2'd2;
  localparam logic [1:0] REG_SLOT_NUMBER    = 2'd3;

  typedef enum logic {
    LAYOUT_COMPAT = 1'b0,
    LAYOUT_FULL   = 1'b1
  } layout_t;

  typedef struct packed {
    logic [1:0]         layout_mode;
    logic [DZ_SQ_W-1:0] left_dz_sq;
    logic [DZ_SQ_W-1:0] right_dz_sq;
    logic               slot_number;
  } cfg_t;

  typedef struct packed {
    logic [CAP_DEPTH-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } snap_t;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic [15:0]        buttons;
    logic               layout_used;
    logic               controller_slot;
  } result_t;

  function automatic logic signed [15:0] scale_axis(input logic [7:0] v);
    logic signed [8:0]  s;
    logic signed [16:0] c;
    logic signed [15:0] r;
    s = $signed({1'b0, v}) - 9'sd128;
    c = $signed({s, 8'b0}) + $signed({{8{s[8]}}, s});
    if (c < -17'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = c[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] map_buttons(input logic [7:0] btn,
                                              input logic [7:0] sh,
                                              input logic [7:0] ex);
    logic [15:0] b;
    b = '0;
    unique case (btn[3:0])
      4'd0:    b[3:0] = 4'b0001;
      4'd1:    b[3:0] = 4'b1001;
      4'd2:    b[3:0] = 4'b1000;
      4'd3:    b[3:0] = 4'b1010;
      4'd4:    b[3:0] = 4'b0010;
      4'd5:    b[3:0] = 4'b0110;
      4'd6:    b[3:0] = 4'b0100;
      4'd7:    b[3:0] = 4'b0101;
      default: b[3:0] = 4'b0000;
    endcase
    b[14] = btn[4];
    b[12] = btn[5];
    b[13] = btn[6];
    b[15] = btn[7];
    b[8]  = sh[0];
    b[9]  = sh[1];
    b[5]  = sh[4];
    b[4]  = sh[5];
    b[6]  = sh[6];
    b[7]  = sh[7];
    b[10] = ex[0];
    return b;
  endfunction

endpackage

FILE: hw/rtl/ghrm_if.sv
// Valid/ready channel interfaces for report bytes and mapped results.
interface ghrm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ghrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;
  logic [15:0]        buttons;
  logic               layout_used;
  logic               controller_slot;

  modport source (output valid, output left_x, output left_y, output right_x,
                  output right_y, output left_trigger, output right_trigger,
                  output buttons, output layout_used, output controller_slot,
                  input ready);
  modport sink (input valid, input left_x, input left_y, input right_x,
                input right_y, input left_trigger, input right_trigger,
                input buttons, input layout_used, input controller_slot,
                output ready);
endinterface

FILE: hw/rtl/ghrm_cfg.sv
// APB register file: layout mode, deadzone radii (kept squared) and slot number.
module ghrm_cfg
  import ghrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [1:0]         layout_mode_r;
  logic [DZ_W-1:0]    left_dz_r;
  logic [DZ_W-1:0]    right_dz_r;
  logic               slot_r;
  logic [DZ_SQ_W-1:0] left_dz_sq_r;
  logic [DZ_SQ_W-1:0] right_dz_sq_r;
  logic               wr_en;
  logic [1:0]         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_mode_r <= LAYOUT_MODE_RST;
      left_dz_r     <= LEFT_DZ_RST;
      right_dz_r    <= RIGHT_DZ_RST;
      slot_r        <= 1'b0;
      left_dz_sq_r  <= DZ_SQ_W'(LEFT_DZ_RST) * DZ_SQ_W'(LEFT_DZ_RST);
      right_dz_sq_r <= DZ_SQ_W'(RIGHT_DZ_RST) * DZ_SQ_W'(RIGHT_DZ_RST);
    end else begin
      left_dz_sq_r  <= DZ_SQ_W'(left_dz_r) * DZ_SQ_W'(left_dz_r);
      right_dz_sq_r <= DZ_SQ_W'(right_dz_r) * DZ_SQ_W'(right_dz_r);
      if (wr_en) begin
        unique case (reg_sel)
          REG_LAYOUT_MODE:    layout_mode_r <= pwdata[1:0];
          REG_LEFT_DEADZONE:  left_dz_r     <= pwdata[DZ_W-1:0];
          REG_RIGHT_DEADZONE: right_dz_r    <= pwdata[DZ_W-1:0];
          REG_SLOT_NUMBER:    slot_r        <= pwdata[0];
          default:            slot_r        <= slot_r;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LAYOUT_MODE:    prdata = {30'b0, layout_mode_r};
      REG_LEFT_DEADZONE:  prdata = {17'b0, left_dz_r};
      REG_RIGHT_DEADZONE: prdata = {17'b0, right_dz_r};
      REG_SLOT_NUMBER:    prdata = {31'b0, slot_r};
      default:            prdata = '0;
    endcase
  end

  assign cfg.layout_mode = layout_mode_r;
  assign cfg.left_dz_sq  = left_dz_sq_r;
  assign cfg.right_dz_sq = right_dz_sq_r;
  assign cfg.slot_number = slot_r;

endmodule

FILE: hw/rtl/ghrm_capture.sv
// Byte collector: counts report bytes, keeps the head bytes, snapshots on the last byte.
module ghrm_capture
  import ghrm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ghrm_in_if.sink       in_ch,
  output logic          snap_valid,
  input  logic          snap_ready,
  output snap_t         snap
);

  logic [LEN_W-1:0]     count_r;
  logic [7:0]           cap_r [CAP_DEPTH];
  logic                 snap_valid_r;
  snap_t                snap_r;
  snap_t                snap_nxt;
  logic                 accept;
  logic                 room;
  logic [LEN_W-1:0]     count_inc;

  assign in_ch.ready = !snap_valid_r || snap_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = count_r < LEN_W'(MAX_REPORT_BYTES);
  assign count_inc   = room ? count_r + LEN_W'(1) : count_r;

  always_comb begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      snap_nxt.bytes[i] = (count_r == LEN_W'(i)) ? in_ch.data_byte : cap_r[i];
    end
    snap_nxt.len = count_inc;
  end

  always_ff @(posedge clk) begin
    if (accept && count_r < LEN_W'(CAP_DEPTH)) begin
      cap_r[count_r[CAP_IDX_W-1:0]] <= in_ch.data_byte;
    end
    if (accept && in_ch.last_byte) begin
      snap_r <= snap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= in_ch.last_byte ? '0 : count_inc;
      end
      if (in_ch.ready) begin
        snap_valid_r <= accept && in_ch.last_byte;
      end
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

FILE: hw/rtl/ghrm_decode.sv
// Report decoder: prefix strip, layout choice and lock, stick scaling, button mapping.
module ghrm_decode
  import ghrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    snap_valid,
  output logic    snap_ready,
  input  snap_t   snap,
  output logic    mid_valid,
  input  logic    mid_ready,
  output result_t mid
);

  logic             seen_r;
  layout_t          cur_layout_r;
  logic             mid_valid_r;
  result_t          mid_r;
  result_t          mid_nxt;
  logic             shift;
  logic [7:0]       p [PAYLOAD_BYTES];
  logic [LEN_W-1:0] len;
  layout_t          layout_pre;
  layout_t          layout_det;
  layout_t          layout_fin;
  logic             ok_pre;
  logic             ok_det;
  logic             emit;
  logic             fire;
  logic [7:0]       btn;
  logic [7:0]       sh;
  logic [7:0]       ex;

  assign snap_ready = !mid_valid_r || mid_ready;
  assign fire       = snap_valid && snap_ready;

  always_comb begin
    shift = (snap.len >= LEN_W'(PREFIXED_MIN_LEN)) &&
            (snap.bytes[0] == PREFIX_A || snap.bytes[0] == PREFIX_B);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      p[k] = shift ? snap.bytes[k + 1] : snap.bytes[k];
    end
    len = snap.len - LEN_W'(shift);

    if (seen_r) begin
      layout_pre = cur_layout_r;
    end else begin
      layout_pre = (cfg.layout_mode == MODE_FULL) ? LAYOUT_FULL : LAYOUT_COMPAT;
    end
    ok_pre = len >= ((layout_pre == LAYOUT_FULL) ? LEN_W'(NEED_FULL) : LEN_W'(NEED_COMPAT));

    if (cfg.layout_mode[1]) begin
      layout_det = (p[8][3:0] == DPAD_NEUTRAL && p[5][3:0] != DPAD_NEUTRAL) ?
                   LAYOUT_FULL : LAYOUT_COMPAT;
    end else begin
      layout_det = layout_pre;
    end
    ok_det = len >= ((layout_det == LAYOUT_FULL) ? LEN_W'(NEED_FULL) : LEN_W'(NEED_COMPAT));

    layout_fin = seen_r ? cur_layout_r : layout_det;
    emit       = ok_pre && (seen_r || ok_det);

    if (layout_fin == LAYOUT_FULL) begin
      mid_nxt.left_trigger  = p[5];
      mid_nxt.right_trigger = p[6];
      btn = p[8];
      sh  = p[9];
      ex  = p[10];
    end else begin
      btn = p[5];
      sh  = p[6];
      ex  = p[7];
      mid_nxt.left_trigger  = p[8];
      mid_nxt.right_trigger = p[9];
    end

    mid_nxt.left_x          = scale_axis(p[1]);
    mid_nxt.left_y          = -scale_axis(p[2]);
    mid_nxt.right_x         = scale_axis(p[3]);
    mid_nxt.right_y         = -scale_axis(p[4]);
    mid_nxt.buttons         = map_buttons(btn, sh, ex);
    mid_nxt.layout_used     = layout_fin;
    mid_nxt.controller_slot = cfg.slot_number;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mid_r <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      cur_layout_r <= LAYOUT_COMPAT;
      mid_valid_r  <= 1'b0;
    end else begin
      if (fire && !seen_r && ok_pre) begin
        seen_r       <= 1'b1;
        cur_layout_r <= layout_det;
      end
      if (snap_ready) begin
        mid_valid_r <= snap_valid && emit;
      end
    end
  end

  assign mid_valid = mid_valid_r;
  assign mid       = mid_r;

endmodule

FILE: hw/rtl/ghrm_deadzone.sv
// Radial deadzone: squared-radius compare per stick, then the result register.
module ghrm_deadzone
  import ghrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      mid_valid,
  output logic      mid_ready,
  input  result_t   mid,
  ghrm_out_if.source out_ch
);

  logic               out_valid_r;
  result_t            res_r;
  result_t            res_nxt;
  logic               left_zero;
  logic               right_zero;

  function automatic logic inside_dz(input logic signed [15:0] x,
                                     input logic signed [15:0] y,
                                     input logic [DZ_SQ_W-1:0] dz_sq);
    logic [DZ_W-1:0]    ax;
    logic [DZ_W-1:0]    ay;
    logic [DZ_SQ_W:0]   r2;
    ax = x[15] ? DZ_W'(-x) : DZ_W'(x);
    ay = y[15] ? DZ_W'(-y) : DZ_W'(y);
    r2 = (DZ_SQ_W + 1)'(ax) * (DZ_SQ_W + 1)'(ax) +
         (DZ_SQ_W + 1)'(ay) * (DZ_SQ_W + 1)'(ay);
    return r2 < {1'b0, dz_sq};
  endfunction

  assign mid_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    left_zero  = inside_dz(mid.left_x, mid.left_y, cfg.left_dz_sq);
    right_zero = inside_dz(mid.right_x, mid.right_y, cfg.right_dz_sq);
    res_nxt = mid;
    if (left_zero) begin
      res_nxt.left_x = '0;
      res_nxt.left_y = '0;
    end
    if (right_zero) begin
      res_nxt.right_x = '0;
      res_nxt.right_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mid_ready) begin
      out_valid_r <= mid_valid;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.left_x          = res_r.left_x;
  assign out_ch.left_y          = res_r.left_y;
  assign out_ch.right_x         = res_r.right_x;
  assign out_ch.right_y         = res_r.right_y;
  assign out_ch.left_trigger    = res_r.left_trigger;
  assign out_ch.right_trigger   = res_r.right_trigger;
  assign out_ch.buttons         = res_r.buttons;
  assign out_ch.layout_used     = res_r.layout_used;
  assign out_ch.controller_slot = res_r.controller_slot;

endmodule

FILE: hw/rtl/gamepad_hid_report_mapper.sv
// Top level of the gamepad input report mapper.
// Report bytes enter one per cycle with the last byte flagged; each complete report
// long enough for its layout yields one result, registered in turn in the snapshot,
// decode and deadzone registers, and the block takes a byte every cycle as
// long as the result side keeps up. Reports of 78 bytes or more that start with 0x31
// or 0x11 are read one byte further on. The first report long enough for the
// configured layout locks the layout until reset; layout_mode 2 or 3 picks it from
// the neutral d-pad nibble. Registers (APB, byte address 4*i): 0 layout_mode,
// 1 left_deadzone, 2 right_deadzone, 3 slot_number. A deadzone change passes through
// the radius register and then the squared-radius register before the compare uses it.
module gamepad_hid_report_mapper
  import ghrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ghrm_in_if.sink     in_ch,
  ghrm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    snap_valid;
  logic    snap_ready;
  snap_t   snap;
  logic    mid_valid;
  logic    mid_ready;
  result_t mid;

  ghrm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ghrm_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ghrm_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid        (mid)
  );

  ghrm_deadzone u_deadzone (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_ch    (out_ch)
  );

endmodule
